[design/fqd_pkg.sv]
// Shared constants, types and ring arithmetic for the FIFO queue with delete.
`timescale 1ns / 1ps

package fqd_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int LEN_W  = 5;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_DEL = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // one port of the entry memory: one write and one read address per cycle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // finished result handed from the sequencer to the output register
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  length;
   } result_type;

   // ring position of the entry that lies off places after the head
   function automatic logic [ADDR_W-1:0] ring_pos(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

[design/fqd_ram.sv]
// Entry storage: single write port, single registered read port.
`timescale 1ns / 1ps

module fqd_ram (
   input  logic                       clock,
   input  fqd_pkg::mem_req_type       mem_req,
   output logic [fqd_pkg::DATA_W-1:0] rd_data
);

   logic [fqd_pkg::DATA_W-1:0] mem_ff [fqd_pkg::DEPTH];
   logic [fqd_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fqd_ctrl.sv]
// Command sequencer: head/count registers, shared ring adder and compare unit.
`timescale 1ns / 1ps

module fqd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fqd_pkg::CMD_W-1:0]   cmd,
   input  logic [fqd_pkg::DATA_W-1:0]  value,
   input  logic                        take,
   output logic                        ready,
   output logic                        done,
   output fqd_pkg::result_type         result,
   output fqd_pkg::mem_req_type        mem_req,
   input  logic [fqd_pkg::DATA_W-1:0]  rd_data
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_FETCH   = 6'b000010,
      S_MATCH   = 6'b000100,
      S_MOVE_RD = 6'b001000,
      S_MOVE_WR = 6'b010000,
      S_DONE    = 6'b100000
   } state_type;

   state_type                      state_ff, state_in;
   logic [fqd_pkg::ADDR_W-1:0]     head_ff, head_in;
   logic [fqd_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [fqd_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic [fqd_pkg::CMD_W-1:0]      cmd_ff, cmd_in;
   logic [fqd_pkg::DATA_W-1:0]     key_ff, key_in;
   logic [fqd_pkg::STAT_W-1:0]     status_ff, status_in;
   logic [fqd_pkg::DATA_W-1:0]     data_ff, data_in;

   logic [fqd_pkg::CNT_W-1:0]      idx_next;
   logic [fqd_pkg::CNT_W-1:0]      offset;
   logic [fqd_pkg::ADDR_W-1:0]     addr;
   logic                           hit;
   logic                           full;
   logic                           empty;

   assign idx_next = idx_ff + fqd_pkg::CNT_W'(1);
   assign full     = (count_ff == fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
   assign empty    = (count_ff == '0);

   // shared ring adder: tail on enqueue, next entry while moving, else scan index
   always_comb begin
      priority case (1'b1)
         state_ff == S_IDLE:    offset = count_ff;
         state_ff == S_MOVE_RD: offset = idx_next;
         default:               offset = idx_ff;
      endcase
   end
   assign addr = fqd_pkg::ring_pos(head_ff, offset);

   // shared compare unit
   assign hit = (rd_data == key_ff);

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      key_in    = key_ff;
      status_in = status_ff;
      data_in   = data_ff;
      mem_req   = '0;
      mem_req.wr_addr = addr;
      mem_req.rd_addr = addr;
      mem_req.wr_data = (state_ff == S_IDLE) ? value : rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd;
               key_in    = value;
               idx_in    = '0;
               data_in   = '0;
               status_in = fqd_pkg::STAT_OK;
               state_in  = S_DONE;
               unique case (cmd)
                  fqd_pkg::CMD_ENQ: begin
                     if (full) begin
                        status_in = fqd_pkg::STAT_FULL;
                     end else begin
                        mem_req.wr_en = 1'b1;
                        count_in      = count_ff + fqd_pkg::CNT_W'(1);
                     end
                  end
                  fqd_pkg::CMD_DEQ: begin
                     if (empty) status_in = fqd_pkg::STAT_EMPTY;
                     else       state_in  = S_FETCH;
                  end
                  fqd_pkg::CMD_DEL: begin
                     if (empty) status_in = fqd_pkg::STAT_NOT_FOUND;
                     else       state_in  = S_FETCH;
                  end
                  default: ;  // unused code: no change, status ok
               endcase
            end
         end
         S_FETCH: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_MATCH;
         end
         S_MATCH: begin
            if (cmd_ff == fqd_pkg::CMD_DEQ) begin
               data_in  = rd_data;
               head_in  = fqd_pkg::ring_pos(head_ff, fqd_pkg::CNT_W'(1));
               count_in = count_ff - fqd_pkg::CNT_W'(1);
               state_in = S_DONE;
            end else if (hit) begin
               state_in = S_MOVE_RD;
            end else if (idx_next == count_ff) begin
               status_in = fqd_pkg::STAT_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_FETCH;
            end
         end
         S_MOVE_RD: begin
            // pull the entry behind the gap, or finish once the gap is at the tail
            if (idx_next < count_ff) begin
               mem_req.rd_en = 1'b1;
               state_in      = S_MOVE_WR;
            end else begin
               count_in = count_ff - fqd_pkg::CNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_MOVE_WR: begin
            mem_req.wr_en = 1'b1;
            idx_in        = idx_next;
            state_in      = S_MOVE_RD;
         end
         S_DONE: begin
            if (take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      cmd_ff    <= cmd_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign ready         = (state_ff == S_IDLE);
   assign done          = (state_ff == S_DONE);
   assign result.status = status_ff;
   assign result.data   = data_ff;
   assign result.length = fqd_pkg::LEN_W'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fqd_pkg::CNT_W'(fqd_pkg::DEPTH))
      else $error("entry count above depth");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == S_IDLE || state_ff == S_MOVE_WR))
      else $error("memory write outside enqueue or move");

   a_move_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE_RD || state_ff == S_MOVE_WR) |-> idx_ff < count_ff)
      else $error("move index past the tail");

   a_enq_count: assert property (@(posedge clock) disable iff (reset)
      (start && ready && cmd == fqd_pkg::CMD_ENQ && !full)
      |=> count_ff == $past(count_ff) + fqd_pkg::CNT_W'(1))
      else $error("enqueue did not grow the count");

   a_hold_in_done: assert property (@(posedge clock) disable iff (reset)
      (done && !take) |=> (done && $stable(count_ff) && $stable(status_ff)))
      else $error("result changed while waiting");

endmodule

[design/fifo_queue_with_delete.sv]
// Top level: bounded FIFO of 32-bit handles with enqueue, dequeue and delete by value.
`timescale 1ns / 1ps

// One command word is taken at a time; req_tready is high only while the sequencer
// is idle. Each command returns exactly one rsp word with status, dequeued data
// (zero unless a dequeue succeeds) and the length after the command. Enqueue and
// error cases post the result straight away; dequeue fetches the head entry first.
// Delete fetches and compares each entry from the head until it finds the handle,
// then closes the gap by reading each later entry and writing it one place toward
// the head, and then posts the result; a miss posts once the last entry is compared.
// The entry memory has a registered read, so each entry needs a fetch and a compare,
// or a read and a write, in turn. The rsp side has its own output register, so
// a finished word waiting on rsp_tready does not stop the sequencer from posting
// and going idle once the register is free. No clearing pass after reset: unused
// entries are never read.
module fifo_queue_with_delete (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [36:32] length, [39:37] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   fqd_pkg::mem_req_type        mem_req;
   fqd_pkg::result_type         result;
   logic [fqd_pkg::DATA_W-1:0]  rd_data;
   logic                        ctrl_ready;
   logic                        ctrl_done;
   logic                        start;
   logic                        take;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   fqd_pkg::result_type         rsp_word_ff, rsp_word_in;

   assign req_tready = ctrl_ready;
   assign start      = req_tvalid & req_tready;

   // result moves into the output register once it is empty or being drained
   assign take = ctrl_done & (~rsp_valid_ff | rsp_tready);

   fqd_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (req_tuser),
      .value   (req_tdata),
      .take    (take),
      .ready   (ctrl_ready),
      .done    (ctrl_done),
      .result  (result),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   fqd_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_word_ff.status;
   assign rsp_tdata  = {3'b000, rsp_word_ff.length, rsp_word_ff.data};

endmodule
